// ===== design/dfo_pkg.sv =====
// dfo_pkg: shared types, register codes, reset values and the step microprogram
// for the drag fall stepper. No dependencies; the design modules use it.
package dfo_pkg;

   localparam int DFO_VALUE_WIDTH   = 32;
   localparam int DFO_FRACTION_BITS = 24;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int STEP_W      = 16;
   localparam int OUT_VEL_W   = 32;
   localparam int PC_W        = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_METHOD_SELECT    = 3'd0,
      CSR_STEP_SIZE        = 3'd1,
      CSR_GRAVITY          = 3'd2,
      CSR_DRAG_RATIO       = 3'd3,
      CSR_SETTLE_TOLERANCE = 3'd4,
      CSR_INITIAL_VELOCITY = 3'd5,
      CSR_STEP_LIMIT       = 3'd6
   } csr_index_type;

   localparam logic        RST_METHOD_SELECT    = 1'b1;
   localparam logic [23:0] RST_STEP_SIZE        = 24'd167772;
   localparam logic [30:0] RST_GRAVITY          = 31'd164584489;
   localparam logic [23:0] RST_DRAG_RATIO       = 24'd41943;
   localparam logic [23:0] RST_SETTLE_TOLERANCE = 24'd25166;
   localparam logic [31:0] RST_INITIAL_VELOCITY = 32'd164584489;
   localparam logic [15:0] RST_STEP_LIMIT       = 16'd5001;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MUL,
      OP_ADD,
      OP_SUB,
      OP_DIV6,
      OP_CHECK
   } dfo_op_type;

   typedef enum logic [3:0] {
      SRC_ZERO,
      SRC_V,
      SRC_U,
      SRC_K,
      SRC_S,
      SRC_P,
      SRC_G,
      SRC_KD,
      SRC_H
   } dfo_src_type;

   typedef enum logic [1:0] {
      DST_U,
      DST_K,
      DST_S,
      DST_P
   } dfo_dst_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_WRITE
   } dfo_state_type;

   typedef struct packed {
      dfo_op_type       op;
      dfo_src_type      sa;
      dfo_src_type      sb;
      dfo_dst_type      dst;
      logic             half;
      logic [PC_W-1:0]  nxt;
      logic [PC_W-1:0]  nxt_euler;
   } dfo_uop_type;

   typedef struct packed {
      logic        issue;
      logic        load_run;
      logic        commit;
      dfo_uop_type uop;
   } dfo_ctl_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic euler;
      logic last;
   } dfo_sts_type;

   localparam logic [PC_W-1:0] PC_START = 5'd0;
   localparam logic [PC_W-1:0] PC_DIFF  = 5'd27;
   localparam logic [PC_W-1:0] PC_EULER = 5'd29;

   function automatic dfo_uop_type mk_uop(input dfo_op_type op, input dfo_src_type sa,
                                          input dfo_src_type sb, input dfo_dst_type dst,
                                          input logic half, input logic [PC_W-1:0] nxt);
      dfo_uop_type u;
      u.op        = op;
      u.sa        = sa;
      u.sb        = sb;
      u.dst       = dst;
      u.half      = half;
      u.nxt       = nxt;
      u.nxt_euler = nxt;
      return u;
   endfunction

   // one integration step; derivative f(x) = g - kd*x*x takes three entries
   function automatic dfo_uop_type dfo_ucode(input logic [PC_W-1:0] pc);
      dfo_uop_type     u;
      logic [PC_W-1:0] seq;
      seq = pc + 1'b1;
      case (pc)
         // k1 = f(v)
         5'd0:  u = mk_uop(OP_MUL,   SRC_V,  SRC_V,    DST_P, 1'b0, seq);
         5'd1:  u = mk_uop(OP_MUL,   SRC_KD, SRC_P,    DST_P, 1'b0, seq);
         5'd2:  begin
            u = mk_uop(OP_SUB, SRC_G, SRC_P, DST_K, 1'b0, seq);
            u.nxt_euler = PC_EULER;
         end
         // k2 = f(v + k1*h/2)
         5'd3:  u = mk_uop(OP_ADD,   SRC_K,  SRC_ZERO, DST_S, 1'b0, seq);
         5'd4:  u = mk_uop(OP_MUL,   SRC_K,  SRC_H,    DST_P, 1'b1, seq);
         5'd5:  u = mk_uop(OP_ADD,   SRC_V,  SRC_P,    DST_U, 1'b0, seq);
         5'd6:  u = mk_uop(OP_MUL,   SRC_U,  SRC_U,    DST_P, 1'b0, seq);
         5'd7:  u = mk_uop(OP_MUL,   SRC_KD, SRC_P,    DST_P, 1'b0, seq);
         5'd8:  u = mk_uop(OP_SUB,   SRC_G,  SRC_P,    DST_K, 1'b0, seq);
         5'd9:  u = mk_uop(OP_ADD,   SRC_S,  SRC_K,    DST_S, 1'b0, seq);
         5'd10: u = mk_uop(OP_ADD,   SRC_S,  SRC_K,    DST_S, 1'b0, seq);
         // k3 = f(v + k2*h/2)
         5'd11: u = mk_uop(OP_MUL,   SRC_K,  SRC_H,    DST_P, 1'b1, seq);
         5'd12: u = mk_uop(OP_ADD,   SRC_V,  SRC_P,    DST_U, 1'b0, seq);
         5'd13: u = mk_uop(OP_MUL,   SRC_U,  SRC_U,    DST_P, 1'b0, seq);
         5'd14: u = mk_uop(OP_MUL,   SRC_KD, SRC_P,    DST_P, 1'b0, seq);
         5'd15: u = mk_uop(OP_SUB,   SRC_G,  SRC_P,    DST_K, 1'b0, seq);
         5'd16: u = mk_uop(OP_ADD,   SRC_S,  SRC_K,    DST_S, 1'b0, seq);
         5'd17: u = mk_uop(OP_ADD,   SRC_S,  SRC_K,    DST_S, 1'b0, seq);
         // k4 = f(v + k3*h)
         5'd18: u = mk_uop(OP_MUL,   SRC_K,  SRC_H,    DST_P, 1'b0, seq);
         5'd19: u = mk_uop(OP_ADD,   SRC_V,  SRC_P,    DST_U, 1'b0, seq);
         5'd20: u = mk_uop(OP_MUL,   SRC_U,  SRC_U,    DST_P, 1'b0, seq);
         5'd21: u = mk_uop(OP_MUL,   SRC_KD, SRC_P,    DST_P, 1'b0, seq);
         5'd22: u = mk_uop(OP_SUB,   SRC_G,  SRC_P,    DST_K, 1'b0, seq);
         5'd23: u = mk_uop(OP_ADD,   SRC_S,  SRC_K,    DST_S, 1'b0, seq);
         // v_new = v + round(S*h)/6
         5'd24: u = mk_uop(OP_MUL,   SRC_S,  SRC_H,    DST_P, 1'b0, seq);
         5'd25: u = mk_uop(OP_DIV6,  SRC_P,  SRC_ZERO, DST_P, 1'b0, seq);
         5'd26: u = mk_uop(OP_ADD,   SRC_V,  SRC_P,    DST_U, 1'b0, seq);
         // settle check on |v - v_new|
         5'd27: u = mk_uop(OP_SUB,   SRC_V,  SRC_U,    DST_P, 1'b0, seq);
         5'd28: u = mk_uop(OP_CHECK, SRC_P,  SRC_ZERO, DST_P, 1'b0, PC_START);
         // euler: v_new = v + k1*h
         5'd29: u = mk_uop(OP_MUL,   SRC_K,  SRC_H,    DST_P, 1'b0, seq);
         5'd30: u = mk_uop(OP_ADD,   SRC_V,  SRC_P,    DST_U, 1'b0, PC_DIFF);
         default: u = mk_uop(OP_NOP, SRC_ZERO, SRC_ZERO, DST_P, 1'b0, PC_START);
      endcase
      return u;
   endfunction

endpackage

// ===== design/dfo_req_if.sv =====
// dfo_req_if: request channel carrying the restart flag with valid/ready.
// Depends on nothing.
interface dfo_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// ===== design/dfo_rsp_if.sv =====
// dfo_rsp_if: result channel carrying velocity, step index and end flags.
// Depends on nothing.
interface dfo_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] velocity;
   logic [15:0] step_index;
   logic        last;
   logic        converged;

   modport source (output valid, output velocity, output step_index, output last,
                   output converged, input ready);
   modport sink   (input valid, input velocity, input step_index, input last,
                   input converged, output ready);
endinterface

// ===== design/dfo_mul.sv =====
// dfo_mul: sequential signed multiplier, 16 bits of one operand per cycle,
// with scaling by 2^-F or 2^-(F+1), round half away from zero and saturation. Uses dfo_pkg.
module dfo_mul #(
   parameter int VALUE_WIDTH   = dfo_pkg::DFO_VALUE_WIDTH,
   parameter int FRACTION_BITS = dfo_pkg::DFO_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          half,
   input  logic signed [VALUE_WIDTH-1:0] op_a,
   input  logic signed [VALUE_WIDTH-1:0] op_b,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] product
);

   localparam int W    = VALUE_WIDTH;
   localparam int F    = FRACTION_BITS;
   localparam int NDIG = (W + 15) / 16;
   localparam int YW   = NDIG * 16;
   localparam int PW   = W + YW;
   localparam int CW   = $clog2(NDIG + 1);

   localparam logic [PW-1:0] RND_F   = PW'(1) << (F - 1);
   localparam logic [PW-1:0] RND_H   = PW'(1) << F;
   localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);
   localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          half_ff, half_in;
   logic [W-1:0]  mx_ff, mx_in;
   logic [YW-1:0] my_ff, my_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [W-1:0]  res_ff, res_in;

   logic [W-1:0]  ua, ub, mag_a, mag_b;
   logic [15:0]   digit;
   logic [W+15:0] pp;
   logic [PW-1:0] rnd, q_full, lim;
   logic [W-1:0]  qm;

   always_comb begin
      ua    = op_a;
      ub    = op_b;
      mag_a = ua[W-1] ? (~ua + 1'b1) : ua;
      mag_b = ub[W-1] ? (~ub + 1'b1) : ub;

      digit = my_ff[YW-1 -: 16];
      pp    = (W+16)'(mx_ff) * (W+16)'(digit);

      rnd    = acc_ff + (half_ff ? RND_H : RND_F);
      q_full = half_ff ? (rnd >> (F + 1)) : (rnd >> F);
      lim    = neg_ff ? LIM_NEG : LIM_POS;
      qm     = (q_full >= lim) ? lim[W-1:0] : q_full[W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      half_in = half_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NDIG);
         neg_in  = ua[W-1] ^ ub[W-1];
         half_in = half;
         mx_in   = mag_a;
         my_in   = YW'(mag_b);
         acc_in  = '0;
      end else if (busy_ff && (cnt_ff != '0)) begin
         // most significant digit first
         acc_in = {acc_ff[PW-17:0], 16'b0} + PW'(pp);
         my_in  = {my_ff[YW-17:0], 16'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         res_in  = neg_ff ? (~qm + 1'b1) : qm;
         done_in = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      half_ff <= half_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done    = done_ff;
   assign product = res_ff;

endmodule

// ===== design/dfo_div6.sv =====
// dfo_div6: signed divide by six, eight quotient bits per cycle, rounded half
// away from zero. Uses dfo_pkg for the default width.
module dfo_div6 #(
   parameter int VALUE_WIDTH = dfo_pkg::DFO_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [VALUE_WIDTH-1:0] dividend,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] quotient
);

   localparam int W   = VALUE_WIDTH;
   localparam int ND8 = (W + 7) / 8;
   localparam int QW  = ND8 * 8;
   localparam int CW  = $clog2(ND8 + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [QW-1:0] mq_ff, mq_in;
   logic [2:0]    rem_ff, rem_in;
   logic [W-1:0]  res_ff, res_in;

   logic [W-1:0]  ud, mag;
   logic [2:0]    r;
   logic [3:0]    t;
   logic [7:0]    qb;
   logic [W-1:0]  qv;

   always_comb begin
      ud  = dividend;
      mag = ud[W-1] ? (~ud + 1'b1) : ud;

      // eight restoring steps; the remainder stays below six
      r  = rem_ff;
      qb = '0;
      for (int i = 0; i < 8; i++) begin
         t = {r, mq_ff[QW-1-i]};
         if (t >= 4'd6) begin
            qb[7-i] = 1'b1;
            r       = 3'(t - 4'd6);
         end else begin
            r = t[2:0];
         end
      end

      qv = mq_ff[W-1:0] + W'(rem_ff >= 3'd3);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mq_in   = mq_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(ND8);
         neg_in  = ud[W-1];
         mq_in   = QW'(mag);
         rem_in  = '0;
      end else if (busy_ff && (cnt_ff != '0)) begin
         mq_in  = {mq_ff[QW-9:0], qb};
         rem_in = r;
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         res_in  = neg_ff ? (~qv + 1'b1) : qv;
         done_in = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mq_ff  <= mq_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// ===== design/dfo_dpath.sv =====
// dfo_dpath: configuration registers, working registers, saturating adder,
// settle check and result register. Instantiates dfo_mul and dfo_div6; uses dfo_pkg.
module dfo_dpath #(
   parameter int VALUE_WIDTH   = dfo_pkg::DFO_VALUE_WIDTH,
   parameter int FRACTION_BITS = dfo_pkg::DFO_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [dfo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dfo_pkg::CSR_DATA_W-1:0]      csr_data,
   input  dfo_pkg::dfo_ctl_type                ctl,
   output dfo_pkg::dfo_sts_type                sts,
   output logic [dfo_pkg::OUT_VEL_W-1:0]       out_velocity,
   output logic [dfo_pkg::STEP_W-1:0]          out_step_index,
   output logic                                out_last,
   output logic                                out_converged
);

   localparam int W  = VALUE_WIDTH;
   localparam int EW = ((W > 32) ? W : 32) + 1;
   localparam int SW = dfo_pkg::STEP_W;

   localparam logic [W-1:0]         VMAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]         VMIN_W = {1'b1, {(W-1){1'b0}}};
   localparam logic [EW-1:0]        VMAX_U = (EW'(1) << (W - 1)) - EW'(1);
   localparam logic signed [EW-1:0] VMAX_S = VMAX_U;
   localparam logic signed [EW-1:0] VMIN_S = -VMAX_S - EW'(1);

   // configuration
   logic        method_ff, method_in;
   logic [23:0] step_size_ff, step_size_in;
   logic [30:0] gravity_ff, gravity_in;
   logic [23:0] drag_ff, drag_in;
   logic [23:0] tol_ff, tol_in;
   logic [31:0] init_vel_ff, init_vel_in;
   logic [15:0] limit_ff, limit_in;

   // working registers
   logic [W-1:0]  v_ff, v_in;
   logic [W-1:0]  u_ff, u_in;
   logic [W-1:0]  k_ff, k_in;
   logic [W-1:0]  s_ff, s_in;
   logic [W-1:0]  p_ff, p_in;
   logic [SW-1:0] count_ff, count_in;
   logic          conv_ff, conv_in;

   logic [dfo_pkg::OUT_VEL_W-1:0] out_vel_ff, out_vel_in;
   logic [SW-1:0]                 out_idx_ff, out_idx_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_conv_ff, out_conv_in;

   logic [W-1:0]  h_c, g_c, kd_c, tol_c, iv_c;
   logic signed [EW-1:0] iv_e, u_e;
   logic [W-1:0]  opa, opb, alu_res, wr_val, abs_p;
   logic          wr_alu, wr_en, last;
   logic [SW-1:0] lim_eff;
   logic          mul_start, div_start, mul_done, div_done;
   logic signed [W-1:0] mul_res, div_res;

   function automatic logic [W-1:0] clamp_u(input logic [31:0] raw);
      logic [EW-1:0] ext;
      ext = EW'(raw);
      return (ext > VMAX_U) ? VMAX_W : ext[W-1:0];
   endfunction

   function automatic logic [W-1:0] sat_sum(input logic [W:0] x);
      if (x[W] != x[W-1]) begin
         return x[W] ? VMIN_W : VMAX_W;
      end
      return x[W-1:0];
   endfunction

   always_comb begin
      method_in    = method_ff;
      step_size_in = step_size_ff;
      gravity_in   = gravity_ff;
      drag_in      = drag_ff;
      tol_in       = tol_ff;
      init_vel_in  = init_vel_ff;
      limit_in     = limit_ff;
      if (csr_write) begin
         case (csr_index)
            dfo_pkg::CSR_METHOD_SELECT:    method_in    = csr_data[0];
            dfo_pkg::CSR_STEP_SIZE:        step_size_in = csr_data[23:0];
            dfo_pkg::CSR_GRAVITY:          gravity_in   = csr_data[30:0];
            dfo_pkg::CSR_DRAG_RATIO:       drag_in      = csr_data[23:0];
            dfo_pkg::CSR_SETTLE_TOLERANCE: tol_in       = csr_data[23:0];
            dfo_pkg::CSR_INITIAL_VELOCITY: init_vel_in  = csr_data[31:0];
            dfo_pkg::CSR_STEP_LIMIT:       limit_in     = csr_data[15:0];
            default: ;
         endcase
      end
   end

   // register values brought into the number range
   always_comb begin
      h_c   = clamp_u(32'(step_size_ff));
      g_c   = clamp_u(32'(gravity_ff));
      kd_c  = clamp_u(32'(drag_ff));
      tol_c = clamp_u(32'(tol_ff));
      iv_e  = EW'($signed(init_vel_ff));
      if (iv_e > VMAX_S) begin
         iv_c = VMAX_W;
      end else if (iv_e < VMIN_S) begin
         iv_c = VMIN_W;
      end else begin
         iv_c = iv_e[W-1:0];
      end
   end

   always_comb begin
      case (ctl.uop.sa)
         dfo_pkg::SRC_V:  opa = v_ff;
         dfo_pkg::SRC_U:  opa = u_ff;
         dfo_pkg::SRC_K:  opa = k_ff;
         dfo_pkg::SRC_S:  opa = s_ff;
         dfo_pkg::SRC_P:  opa = p_ff;
         dfo_pkg::SRC_G:  opa = g_c;
         dfo_pkg::SRC_KD: opa = kd_c;
         dfo_pkg::SRC_H:  opa = h_c;
         default:         opa = '0;
      endcase
      case (ctl.uop.sb)
         dfo_pkg::SRC_V:  opb = v_ff;
         dfo_pkg::SRC_U:  opb = u_ff;
         dfo_pkg::SRC_K:  opb = k_ff;
         dfo_pkg::SRC_S:  opb = s_ff;
         dfo_pkg::SRC_P:  opb = p_ff;
         dfo_pkg::SRC_G:  opb = g_c;
         dfo_pkg::SRC_KD: opb = kd_c;
         dfo_pkg::SRC_H:  opb = h_c;
         default:         opb = '0;
      endcase
   end

   assign mul_start = ctl.issue && (ctl.uop.op == dfo_pkg::OP_MUL);
   assign div_start = ctl.issue && (ctl.uop.op == dfo_pkg::OP_DIV6);

   dfo_mul #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .half    (ctl.uop.half),
      .op_a    (opa),
      .op_b    (opb),
      .done    (mul_done),
      .product (mul_res)
   );

   dfo_div6 #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div6 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (opa),
      .done     (div_done),
      .quotient (div_res)
   );

   always_comb begin
      if (ctl.uop.op == dfo_pkg::OP_SUB) begin
         alu_res = sat_sum({opa[W-1], opa} - {opb[W-1], opb});
      end else begin
         alu_res = sat_sum({opa[W-1], opa} + {opb[W-1], opb});
      end
      wr_alu = ctl.issue &&
               ((ctl.uop.op == dfo_pkg::OP_ADD) || (ctl.uop.op == dfo_pkg::OP_SUB));
      wr_en  = wr_alu || mul_done || div_done;
      if (mul_done) begin
         wr_val = mul_res;
      end else if (div_done) begin
         wr_val = div_res;
      end else begin
         wr_val = alu_res;
      end

      // |v - v_new| with the most negative value saturating
      if (p_ff[W-1]) begin
         abs_p = (p_ff == VMIN_W) ? VMAX_W : (~p_ff + 1'b1);
      end else begin
         abs_p = p_ff;
      end

      lim_eff = (limit_ff == '0) ? SW'(1) : limit_ff;
      last    = conv_ff || (({1'b0, count_ff} + (SW+1)'(1)) >= {1'b0, lim_eff});
      u_e     = EW'($signed(u_ff));
   end

   always_comb begin
      v_in        = v_ff;
      u_in        = u_ff;
      k_in        = k_ff;
      s_in        = s_ff;
      p_in        = p_ff;
      count_in    = count_ff;
      conv_in     = conv_ff;
      out_vel_in  = out_vel_ff;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      out_conv_in = out_conv_ff;

      if (wr_en) begin
         case (ctl.uop.dst)
            dfo_pkg::DST_U: u_in = wr_val;
            dfo_pkg::DST_K: k_in = wr_val;
            dfo_pkg::DST_S: s_in = wr_val;
            default:        p_in = wr_val;
         endcase
      end
      if (ctl.issue && (ctl.uop.op == dfo_pkg::OP_CHECK)) begin
         conv_in = abs_p < tol_c;
      end
      if (ctl.load_run) begin
         v_in     = iv_c;
         count_in = '0;
      end
      if (ctl.commit) begin
         v_in        = u_ff;
         count_in    = count_ff + 1'b1;
         out_vel_in  = u_e[dfo_pkg::OUT_VEL_W-1:0];
         out_idx_in  = count_ff;
         out_last_in = last;
         out_conv_in = conv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff    <= dfo_pkg::RST_METHOD_SELECT;
         step_size_ff <= dfo_pkg::RST_STEP_SIZE;
         gravity_ff   <= dfo_pkg::RST_GRAVITY;
         drag_ff      <= dfo_pkg::RST_DRAG_RATIO;
         tol_ff       <= dfo_pkg::RST_SETTLE_TOLERANCE;
         init_vel_ff  <= dfo_pkg::RST_INITIAL_VELOCITY;
         limit_ff     <= dfo_pkg::RST_STEP_LIMIT;
      end else begin
         method_ff    <= method_in;
         step_size_ff <= step_size_in;
         gravity_ff   <= gravity_in;
         drag_ff      <= drag_in;
         tol_ff       <= tol_in;
         init_vel_ff  <= init_vel_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      u_ff        <= u_in;
      k_ff        <= k_in;
      s_ff        <= s_in;
      p_ff        <= p_in;
      count_ff    <= count_in;
      conv_ff     <= conv_in;
      out_vel_ff  <= out_vel_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      out_conv_ff <= out_conv_in;
   end

   assign sts.mul_done = mul_done;
   assign sts.div_done = div_done;
   assign sts.euler    = !method_ff;
   assign sts.last     = last;

   assign out_velocity   = out_vel_ff;
   assign out_step_index = out_idx_ff;
   assign out_last       = out_last_ff;
   assign out_converged  = out_conv_ff;

endmodule

// ===== design/dfo_ctrl.sv =====
// dfo_ctrl: step sequencer; walks the microprogram, waits on the arithmetic
// units and owns the handshakes and the run-finished flag. Uses dfo_pkg.
module dfo_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  dfo_pkg::dfo_sts_type sts,
   output dfo_pkg::dfo_ctl_type ctl
);

   dfo_pkg::dfo_state_type        state_ff, state_in;
   logic [dfo_pkg::PC_W-1:0]      pc_ff, pc_in;
   logic                          finished_ff, finished_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dfo_pkg::PC_W-1:0]      nxt_pc;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ctl          = '0;
      ctl.uop      = dfo_pkg::dfo_ucode(pc_ff);
      nxt_pc       = sts.euler ? ctl.uop.nxt_euler : ctl.uop.nxt;

      case (state_ff)
         dfo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  ctl.load_run = 1'b1;
                  finished_in  = 1'b0;
               end else if (!finished_ff) begin
                  pc_in    = dfo_pkg::PC_START;
                  state_in = dfo_pkg::ST_ISSUE;
               end
            end
         end
         dfo_pkg::ST_ISSUE: begin
            ctl.issue = 1'b1;
            case (ctl.uop.op)
               dfo_pkg::OP_MUL,
               dfo_pkg::OP_DIV6:  state_in = dfo_pkg::ST_WAIT;
               dfo_pkg::OP_CHECK: state_in = dfo_pkg::ST_WRITE;
               default:           pc_in    = nxt_pc;
            endcase
         end
         dfo_pkg::ST_WAIT: begin
            if (sts.mul_done || sts.div_done) begin
               pc_in    = nxt_pc;
               state_in = dfo_pkg::ST_ISSUE;
            end
         end
         dfo_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               finished_in  = sts.last;
               state_in     = dfo_pkg::ST_IDLE;
            end
         end
         default: state_in = dfo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfo_pkg::ST_IDLE;
         pc_ff        <= dfo_pkg::PC_START;
         finished_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/drag_fall_ode_stepper.sv =====
// drag_fall_ode_stepper: integrates dv/dt = g - k*v*v, one step per request
// transfer, forward Euler or fourth-order Runge-Kutta in signed fixed point.
// Uses dfo_pkg, dfo_req_if, dfo_rsp_if, dfo_ctrl and dfo_dpath.
//
// req_chan carries restart. restart = 1 loads initial_velocity, clears the
// step count and opens a run; it gives no result. A step with no open run is
// taken and dropped.
// rsp_chan carries velocity, step_index, last and converged, one transfer per
// step. After a transfer with last = 1 the run is closed until a restart.
// csr_write/csr_index/csr_data write one register per cycle, only while idle;
// the block itself does not enforce this, the user must keep to it.
//
// every product of a step goes through the single shared multiplier, 16 bits
// per cycle, and an RK4 step also through the divide-by-six unit at 8 bits per
// cycle; these units bound how long a step occupies the sequencer.
// the result sits in an output register, so the next request is taken while a
// result waits; only the final write of a step waits for a stalled receiver.
// reset restores the register defaults, empties the output register and
// leaves no run open.
module drag_fall_ode_stepper #(
   parameter int VALUE_WIDTH   = dfo_pkg::DFO_VALUE_WIDTH,
   parameter int FRACTION_BITS = dfo_pkg::DFO_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   dfo_req_if.sink                         req_chan,
   dfo_rsp_if.source                       rsp_chan,
   input  logic                            csr_write,
   input  logic [dfo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dfo_pkg::CSR_DATA_W-1:0]  csr_data
);

   // command and status between sequencer and datapath
   dfo_pkg::dfo_ctl_type ctl;
   dfo_pkg::dfo_sts_type sts;

   logic                          req_ready;
   logic                          rsp_valid;
   logic [dfo_pkg::OUT_VEL_W-1:0] velocity;
   logic [dfo_pkg::STEP_W-1:0]    step_index;
   logic                          last;
   logic                          converged;

   // sequencer: handshakes, run state and microprogram counter
   dfo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_restart (req_chan.restart),
      .req_ready   (req_ready),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_valid),
      .sts         (sts),
      .ctl         (ctl)
   );

   // datapath: registers, shared multiplier, divider and result register
   dfo_dpath #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .ctl            (ctl),
      .sts            (sts),
      .out_velocity   (velocity),
      .out_step_index (step_index),
      .out_last       (last),
      .out_converged  (converged)
   );

   // channel hookup
   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.velocity   = velocity;
   assign rsp_chan.step_index = step_index;
   assign rsp_chan.last       = last;
   assign rsp_chan.converged  = converged;

endmodule
